### rtl/ccj_pkg.sv
// ----------------------------------------------------------------------------
// ccj_pkg
// Shared types, codes and lookup functions for the coin/credit/joystick unit.
// ----------------------------------------------------------------------------
package ccj_pkg;

    // bus access as seen on the input channel
    typedef struct packed {
        logic       cmd;
        logic [1:0] offset;
        logic [7:0] write_data;
        logic [3:0] in0_low;
        logic [3:0] in0_high;
        logic [3:0] in1_low;
        logic [3:0] in1_high;
    } t_in_item;

    // one result per access
    typedef struct packed {
        logic [7:0] read_data;
        logic       lockout_written;
        logic       coin_lockout;
        logic       coin_a_pulse;
        logic       coin_b_pulse;
        logic       out0_written;
        logic [3:0] out0_value;
    } t_out_item;

    // access class decided by the front end
    typedef enum logic [2:0] {
        K_WRITE,
        K_RD_SYS,
        K_RD_JOY1,
        K_RD_JOY2,
        K_RD_NONE
    } t_op_kind;

    typedef struct packed {
        logic [3:0] in0_low;
        logic [3:0] in0_high;
        logic [3:0] in1_low;
        logic [3:0] in1_high;
    } t_switches;

    typedef struct packed {
        t_op_kind   kind;
        logic [2:0] wcmd;
        t_switches  sw;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // write command codes
    localparam logic [2:0] CMD_SETUP     = 3'd1;
    localparam logic [2:0] CMD_CREDIT    = 3'd2;
    localparam logic [2:0] CMD_REMAP_OFF = 3'd3;
    localparam logic [2:0] CMD_REMAP_ON  = 3'd4;
    localparam logic [2:0] CMD_SWITCH    = 3'd5;

    // coinage set-up countdown steps
    localparam logic [2:0] SU_COINS_A   = 3'd4;
    localparam logic [2:0] SU_CREDITS_A = 3'd3;
    localparam logic [2:0] SU_COINS_B   = 3'd2;
    localparam logic [2:0] SU_CREDITS_B = 3'd1;

    localparam logic [7:0] CREDIT_LOCK  = 8'd99;
    localparam logic [7:0] CREDIT_FREE  = 8'd100;
    localparam logic [7:0] TEST_READ    = 8'hbb;
    localparam logic [3:0] LAMP_OFF     = 4'h0c;
    localparam logic [3:0] LAMP_ONE     = 4'h0e;
    localparam logic [3:0] LAMP_BOTH    = 4'h0f;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // joystick direction remap
    function automatic logic [3:0] dir_map(input logic [3:0] j);
        logic [3:0] r;
        unique case (j)
            4'h0: r = 4'hf;
            4'h1: r = 4'he;
            4'h2: r = 4'hd;
            4'h3: r = 4'h5;
            4'h4: r = 4'hc;
            4'h5: r = 4'h9;
            4'h6: r = 4'h7;
            4'h7: r = 4'h6;
            4'h8: r = 4'hb;
            4'h9: r = 4'h3;
            4'ha: r = 4'ha;
            4'hb: r = 4'h4;
            4'hc: r = 4'h1;
            4'hd: r = 4'h2;
            4'he: r = 4'h0;
            default: r = 4'h8;
        endcase
        return r;
    endfunction

    // credits 0..127 to tens/ones nibbles, BCD to 99; tens by 205/2048 (1/10)
    function automatic logic [7:0] bcd_byte(input logic [6:0] c);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(c) * 15'd205;
        tens = prod[14:11];
        ones = c - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

### rtl/ccj_front.sv
// ----------------------------------------------------------------------------
// ccj_front
// Accepts bus accesses and classifies them into queue entries.
// ----------------------------------------------------------------------------
module ccj_front import ccj_pkg::*; (
    input  logic     i_valid,
    input  t_in_item i_data,
    input  t_q_stat  i_q_stat,
    output logic     o_stall,
    output logic     o_push,
    output t_op      o_op
);

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid & ~i_q_stat.full;

    always_comb begin
        o_op.wcmd        = i_data.write_data[2:0];
        o_op.sw.in0_low  = i_data.in0_low;
        o_op.sw.in0_high = i_data.in0_high;
        o_op.sw.in1_low  = i_data.in1_low;
        o_op.sw.in1_high = i_data.in1_high;
        if (i_data.cmd) begin
            o_op.kind = K_WRITE;
        end else begin
            unique case (i_data.offset)
                2'd0:    o_op.kind = K_RD_SYS;
                2'd1:    o_op.kind = K_RD_JOY1;
                2'd2:    o_op.kind = K_RD_JOY2;
                default: o_op.kind = K_RD_NONE;
            endcase
        end
    end

endmodule

### rtl/ccj_queue.sv
// ----------------------------------------------------------------------------
// ccj_queue
// Short FIFO of classified accesses between front and back.
// ----------------------------------------------------------------------------
module ccj_queue import ccj_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op     i_op,
    input  logic    i_pop,
    output t_op     o_op,
    output t_q_stat o_stat
);

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    assign o_op         = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

### rtl/ccj_back.sv
// ----------------------------------------------------------------------------
// ccj_back
// Executes queued accesses: coinage, credits, lamps, joystick, result register.
// ----------------------------------------------------------------------------
module ccj_back import ccj_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_stat   i_q_stat,
    input  t_op       i_op,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    typedef enum logic [1:0] {
        MODE_SWITCH = 2'd0,
        MODE_CREDIT = 2'd1,
        MODE_PLAY   = 2'd2
    } t_mode;

    t_mode     r_mode, n_mode;
    logic [2:0] r_countdown, n_countdown;
    logic [2:0] r_need_a, n_need_a;
    logic [2:0] r_give_a, n_give_a;
    logic [2:0] r_need_b, n_need_b;
    logic [2:0] r_give_b, n_give_b;
    logic [7:0] r_cnt_a, n_cnt_a;
    logic [7:0] r_cnt_b, n_cnt_b;
    logic [6:0] r_credits, n_credits;
    logic [7:0] r_prev_coin, n_prev_coin;
    logic [1:0] r_prev_fire, n_prev_fire;
    logic       r_remap, n_remap;
    logic       r_out_valid;
    t_out_item  r_out, n_out;

    logic [7:0] val8, edg8, cr, cnt_a, cnt_b;
    logic [1:0] val2, edg2, pmask;
    logic [3:0] joy;

    assign o_pop = ~i_q_stat.empty & (~r_out_valid | ~i_stall);

    always_comb begin
        n_mode      = r_mode;
        n_countdown = r_countdown;
        n_need_a    = r_need_a;
        n_give_a    = r_give_a;
        n_need_b    = r_need_b;
        n_give_b    = r_give_b;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_credits   = r_credits;
        n_prev_coin = r_prev_coin;
        n_prev_fire = r_prev_fire;
        n_remap     = r_remap;
        n_out       = '0;
        val8        = ~{i_op.sw.in0_high, i_op.sw.in0_low};
        edg8        = val8 & ~r_prev_coin;
        cr          = {1'b0, r_credits};
        cnt_a       = r_cnt_a;
        cnt_b       = r_cnt_b;
        val2        = ~i_op.sw.in0_low[1:0];
        edg2        = val2 & ~r_prev_fire;
        pmask       = (i_op.kind == K_RD_JOY1) ? 2'b01 : 2'b10;
        joy         = (i_op.kind == K_RD_JOY1) ? i_op.sw.in1_low : i_op.sw.in1_high;

        if (i_op.kind == K_WRITE) begin
            if (r_countdown != '0) begin
                unique case (r_countdown)
                    SU_COINS_A:   n_need_a = i_op.wcmd;
                    SU_CREDITS_A: n_give_a = i_op.wcmd;
                    SU_COINS_B:   n_need_b = i_op.wcmd;
                    SU_CREDITS_B: n_give_b = i_op.wcmd;
                    default: ;
                endcase
                n_countdown = r_countdown - 3'd1;
            end else begin
                unique case (i_op.wcmd)
                    CMD_SETUP: begin
                        n_countdown = SU_COINS_A;
                        n_credits   = '0;
                    end
                    CMD_CREDIT:    n_mode  = MODE_CREDIT;
                    CMD_REMAP_OFF: n_remap = 1'b0;
                    CMD_REMAP_ON:  n_remap = 1'b1;
                    CMD_SWITCH:    n_mode  = MODE_SWITCH;
                    default: ;
                endcase
            end
        end else if (r_mode == MODE_SWITCH) begin
            unique case (i_op.kind)
                K_RD_SYS:  n_out.read_data = {i_op.sw.in0_high, i_op.sw.in0_low};
                K_RD_JOY1: n_out.read_data = {i_op.sw.in1_high, i_op.sw.in1_low};
                default:   n_out.read_data = '0;
            endcase
        end else if (i_op.kind == K_RD_SYS) begin
            n_prev_coin = val8;
            if (r_need_a != '0) begin
                n_out.lockout_written = 1'b1;
                if (cr >= CREDIT_LOCK) begin
                    n_out.coin_lockout = 1'b1;
                end else begin
                    if (edg8[4]) begin
                        cnt_a = r_cnt_a + 8'd1;
                        n_out.coin_a_pulse = 1'b1;
                        n_out.out0_written = 1'b1;
                        n_out.out0_value   = LAMP_OFF;
                        if (cnt_a >= {5'b0, r_need_a}) begin
                            cr    = cr + {5'b0, r_give_a};
                            cnt_a = cnt_a - {5'b0, r_need_a};
                        end
                    end
                    if (edg8[5]) begin
                        cnt_b = r_cnt_b + 8'd1;
                        n_out.coin_b_pulse = 1'b1;
                        n_out.out0_written = 1'b1;
                        n_out.out0_value   = LAMP_OFF;
                        if (cnt_b >= {5'b0, r_need_b}) begin
                            cr    = cr + {5'b0, r_give_b};
                            cnt_b = cnt_b - {5'b0, r_need_b};
                        end
                    end
                    if (edg8[6]) begin
                        cr = cr + 8'd1;
                    end
                end
            end else begin
                cr = CREDIT_FREE;
            end
            n_cnt_a = cnt_a;
            n_cnt_b = cnt_b;

            if (r_mode == MODE_CREDIT) begin
                n_out.out0_written = 1'b1;
                if (cr >= 8'd2) begin
                    n_out.out0_value = LAMP_BOTH;
                end else if (cr >= 8'd1) begin
                    n_out.out0_value = LAMP_ONE;
                end else begin
                    n_out.out0_value = LAMP_OFF;
                end
                // start 2 only looked at without a start 1 edge
                if (edg8[2]) begin
                    if (cr >= 8'd1) begin
                        cr = cr - 8'd1;
                        n_mode = MODE_PLAY;
                        n_out.out0_value = LAMP_OFF;
                    end
                end else if (edg8[3]) begin
                    if (cr >= 8'd2) begin
                        cr = cr - 8'd2;
                        n_mode = MODE_PLAY;
                        n_out.out0_value = LAMP_OFF;
                    end
                end
            end
            n_credits = cr[6:0];
            n_out.read_data = i_op.sw.in0_high[3] ? bcd_byte(cr[6:0]) : TEST_READ;
        end else if (i_op.kind == K_RD_JOY1 || i_op.kind == K_RD_JOY2) begin
            n_prev_fire = (r_prev_fire & ~pmask) | (val2 & pmask);
            n_out.read_data = {2'b00, ~|(val2 & pmask), ~|(edg2 & pmask),
                               r_remap ? dir_map(joy) : joy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SWITCH;
            r_countdown <= '0;
            r_need_a    <= '0;
            r_give_a    <= '0;
            r_need_b    <= '0;
            r_give_b    <= '0;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_credits   <= '0;
            r_prev_coin <= '0;
            r_prev_fire <= '0;
            r_remap     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode      <= n_mode;
                r_countdown <= n_countdown;
                r_need_a    <= n_need_a;
                r_give_a    <= n_give_a;
                r_need_b    <= n_need_b;
                r_give_b    <= n_give_b;
                r_cnt_a     <= n_cnt_a;
                r_cnt_b     <= n_cnt_b;
                r_credits   <= n_credits;
                r_prev_coin <= n_prev_coin;
                r_prev_fire <= n_prev_fire;
                r_remap     <= n_remap;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### rtl/coin_credit_joystick_io_unit.sv
// ----------------------------------------------------------------------------
// coin_credit_joystick_io_unit
// Bus-side arcade coin/credit and joystick input controller.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------
//   access  | in        | i_valid / o_stall  | i_data (t_in_item)
//   result  | out       | o_valid / i_stall  | o_data (t_out_item)
//
// One access per cycle sustained while i_stall is low; each result is
// registered first in the queue and then in the back end's result register.
// A two-entry queue decouples the front from the back; o_stall rises when full.
// A valid result register holds while i_stall is high and the back end waits.
// Synchronous active-low reset returns switch mode, no coinage, zero credits.
// ----------------------------------------------------------------------------
module coin_credit_joystick_io_unit import ccj_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    t_q_stat q_stat;
    t_op     front_op, back_op;
    logic    push, pop;

    ccj_front u_front (
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_q_stat (q_stat),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_op     (front_op)
    );

    ccj_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (back_op),
        .o_stat  (q_stat)
    );

    ccj_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_op     (back_op),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

endmodule

### rtl/ccj_checker.sv
// ----------------------------------------------------------------------------
// ccj_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ccj_checker import ccj_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_lock_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.coin_lockout |-> o_data.lockout_written)
        else $error("lockout set but not driven");

    a_coin_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.coin_a_pulse || o_data.coin_b_pulse) |->
            o_data.lockout_written && !o_data.coin_lockout && o_data.out0_written)
        else $error("coin pulse without unlocked port write");

    a_out0_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.out0_written |-> o_data.out0_value == 4'h0)
        else $error("port 0 value without a write");

endmodule

bind coin_credit_joystick_io_unit ccj_checker u_ccj_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for coin_credit_joystick_io_unit. A short table of
// directed bus accesses is followed by random access streams (coinage set-ups,
// mode commands, coin and start button activity, joystick reads). Each
// accepted access is run through a local model of the unit; results are matched
// in order against it, or a typed row's want, while both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import ccj_pkg::*;

    localparam int ITEM_TARGET    = 550;
    localparam int CALM_LO        = 300;   // stretch with no idling on either side
    localparam int CALM_HI        = 380;
    localparam int PRESSURE_AT    = 150;
    localparam int PRESSURE_LEN   = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SHOWN_ERRORS   = 10;

    localparam logic       ACC_READ  = 1'b0;
    localparam logic       ACC_WRITE = 1'b1;
    localparam logic [1:0] OFS_SYS   = 2'd0;
    localparam logic [1:0] OFS_JOY1  = 2'd1;
    localparam logic [1:0] OFS_JOY2  = 2'd2;
    localparam logic [1:0] OFS_NONE  = 2'd3;

    localparam logic [2:0] CMD_NOP    = 3'd0;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    // bit positions in the inverted port 0 byte
    localparam int SW_START1  = 2;
    localparam int SW_START2  = 3;
    localparam int SW_COIN_A  = 4;
    localparam int SW_COIN_B  = 5;
    localparam int SW_SERVICE = 6;
    localparam int TEST_N_BIT = 3;   // in in0_high, active low

    localparam logic [3:0] COIN_PULSE = 4'hc;
    // joystick remap, entry n at nibble n
    localparam logic [63:0] REMAP_LUT = 64'h8021_4a3b_679c_5def;

    typedef enum logic [1:0] {
        MODE_SWITCH,
        MODE_CREDIT,
        MODE_PLAY
    } t_pred_mode;

    typedef struct {
        t_in_item  acc;
        bit        typed;
        t_out_item want;
    } t_bus_access;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    coin_credit_joystick_io_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // model state
    t_pred_mode  mode;
    logic [2:0]  setup_left;
    logic [2:0]  coins_a, credits_a, coins_b, credits_b;
    logic [7:0]  coin_cnt_a, coin_cnt_b;
    logic [6:0]  credits;
    logic [7:0]  prev_coin_sw;
    logic [1:0]  prev_fire;
    logic        remap_on;

    t_bus_access accesses[$];
    t_out_item   pending_results[$];
    int          n_directed;
    int          acc_idx;
    int          failures;
    int          idle_cycles;
    int          n_results;
    int          n_lockouts;
    int          n_coin_pulses;
    int          n_test_reads;
    int          hold_left;
    int          stall_left;
    bit          pressure_done;

    function automatic void reset_predictor();
        mode         = MODE_SWITCH;
        setup_left   = '0;
        coins_a      = '0;
        credits_a    = '0;
        coins_b      = '0;
        credits_b    = '0;
        coin_cnt_a   = '0;
        coin_cnt_b   = '0;
        credits      = '0;
        prev_coin_sw = '0;
        prev_fire    = '0;
        remap_on     = 1'b0;
    endfunction

    function automatic t_out_item predict_bus_result(t_in_item a);
        t_out_item   r;
        logic [2:0]  d;
        logic [7:0]  sw;
        logic [7:0]  rise;
        int unsigned cr;
        logic [3:0]  joy;
        logic [1:0]  fire;
        logic [1:0]  fire_rise;
        logic [1:0]  sel;
        r = '0;
        if (a.cmd == ACC_WRITE) begin
            d = a.write_data[2:0];
            if (setup_left != 0) begin
                case (setup_left)
                    SU_COINS_A:   coins_a   = d;
                    SU_CREDITS_A: credits_a = d;
                    SU_COINS_B:   coins_b   = d;
                    SU_CREDITS_B: credits_b = d;
                    default: ;
                endcase
                setup_left = setup_left - 3'd1;
            end else begin
                case (d)
                    CMD_SETUP: begin
                        setup_left = SU_COINS_A;
                        credits = '0;
                    end
                    CMD_CREDIT:    mode = MODE_CREDIT;
                    CMD_REMAP_OFF: remap_on = 1'b0;
                    CMD_REMAP_ON:  remap_on = 1'b1;
                    CMD_SWITCH:    mode = MODE_SWITCH;
                    default: ;
                endcase
            end
        end else if (mode == MODE_SWITCH) begin
            if (a.offset == OFS_SYS)
                r.read_data = {a.in0_high, a.in0_low};
            else if (a.offset == OFS_JOY1)
                r.read_data = {a.in1_high, a.in1_low};
        end else if (a.offset == OFS_SYS) begin
            sw = ~{a.in0_high, a.in0_low};
            rise = sw & ~prev_coin_sw;
            prev_coin_sw = sw;
            cr = credits;
            if (coins_a != 0) begin
                r.lockout_written = 1'b1;
                if (cr >= CREDIT_LOCK) begin
                    r.coin_lockout = 1'b1;
                end else begin
                    if (rise[SW_COIN_A]) begin
                        coin_cnt_a = coin_cnt_a + 8'd1;
                        r.coin_a_pulse = 1'b1;
                        r.out0_written = 1'b1;
                        r.out0_value = COIN_PULSE;
                        if (coin_cnt_a >= coins_a) begin
                            cr += credits_a;
                            coin_cnt_a = coin_cnt_a - coins_a;
                        end
                    end
                    if (rise[SW_COIN_B]) begin
                        coin_cnt_b = coin_cnt_b + 8'd1;
                        r.coin_b_pulse = 1'b1;
                        r.out0_written = 1'b1;
                        r.out0_value = COIN_PULSE;
                        // zero coinage on B: every edge pays out
                        if (coin_cnt_b >= coins_b) begin
                            cr += credits_b;
                            coin_cnt_b = coin_cnt_b - coins_b;
                        end
                    end
                    if (rise[SW_SERVICE])
                        cr++;
                end
            end else begin
                cr = CREDIT_FREE;
            end
            if (mode == MODE_CREDIT) begin
                r.out0_written = 1'b1;
                r.out0_value = (cr >= 2) ? LAMP_BOTH : (cr >= 1) ? LAMP_ONE : LAMP_OFF;
                // start 2 only counts without a start 1 edge
                if (rise[SW_START1]) begin
                    if (cr >= 1) begin
                        cr -= 1;
                        mode = MODE_PLAY;
                        r.out0_value = LAMP_OFF;
                    end
                end else if (rise[SW_START2]) begin
                    if (cr >= 2) begin
                        cr -= 2;
                        mode = MODE_PLAY;
                        r.out0_value = LAMP_OFF;
                    end
                end
            end
            credits = cr[6:0];
            cr = credits;
            if (!a.in0_high[TEST_N_BIT])
                r.read_data = TEST_READ;
            else
                r.read_data = 8'(((cr / 10) * 16) + (cr % 10));
        end else if (a.offset == OFS_JOY1 || a.offset == OFS_JOY2) begin
            sel = a.offset;
            joy = (a.offset == OFS_JOY1) ? a.in1_low : a.in1_high;
            fire = ~a.in0_low[1:0];
            fire_rise = fire & ~prev_fire;
            prev_fire = (prev_fire & ~sel) | (fire & sel);
            if (remap_on)
                joy = REMAP_LUT[{joy, 2'b00} +: 4];
            r.read_data = {2'b00, (fire & sel) == 2'b00, (fire_rise & sel) == 2'b00, joy};
        end
        return r;
    endfunction

    function automatic t_in_item make_access(logic cmd, logic [1:0] off, logic [7:0] wd,
                                             logic [3:0] i0l, logic [3:0] i0h,
                                             logic [3:0] i1l, logic [3:0] i1h);
        t_in_item a;
        a.cmd        = cmd;
        a.offset     = off;
        a.write_data = wd;
        a.in0_low    = i0l;
        a.in0_high   = i0h;
        a.in1_low    = i1l;
        a.in1_high   = i1h;
        return a;
    endfunction

    function automatic void push_access(t_in_item a);
        t_bus_access s;
        s.acc   = a;
        s.typed = 1'b0;
        s.want  = '0;
        accesses.push_back(s);
    endfunction

    // directed table row; want is used only where typed is set
    function automatic void add_row(logic cmd, logic [1:0] off, logic [7:0] wd,
                                    logic [3:0] i0l, logic [3:0] i0h,
                                    logic [3:0] i1l, logic [3:0] i1h,
                                    bit typed, logic [7:0] rd, logic o0w, logic [3:0] o0);
        t_bus_access s;
        s.acc   = make_access(cmd, off, wd, i0l, i0h, i1l, i1h);
        s.typed = typed;
        s.want  = '0;
        s.want.read_data    = rd;
        s.want.out0_written = o0w;
        s.want.out0_value   = o0;
        accesses.push_back(s);
    endfunction

    // active-low switches, mostly released
    function automatic logic [3:0] switch_nibble();
        logic [3:0] n;
        n = 4'hf;
        for (int b = 0; b < 4; b++)
            if ($urandom_range(0, 3) == 0)
                n[b] = 1'b0;
        return n;
    endfunction

    function automatic t_in_item random_read(logic [1:0] off);
        return make_access(ACC_READ, off, 8'($urandom), switch_nibble(), switch_nibble(),
                           4'($urandom), 4'($urandom));
    endfunction

    function automatic t_in_item random_write(logic [7:0] wd);
        return make_access(ACC_WRITE, 2'($urandom), wd, 4'($urandom), 4'($urandom),
                           4'($urandom), 4'($urandom));
    endfunction

    function automatic void build_directed();
        add_row(ACC_READ,  OFS_SYS,  8'h00, 4'h5, 4'ha, 4'h0, 4'h0, 1, 8'ha5, 0, 4'h0);
        add_row(ACC_READ,  OFS_JOY1, 8'hff, 4'hf, 4'hf, 4'hf, 4'h0, 1, 8'h0f, 0, 4'h0);
        add_row(ACC_READ,  OFS_JOY2, 8'h00, 4'hf, 4'hf, 4'hf, 4'hf, 1, 8'h00, 0, 4'h0);
        add_row(ACC_READ,  OFS_NONE, 8'h00, 4'h0, 4'h0, 4'hf, 4'hf, 1, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_NONE, {5'h1f, CMD_SPARE7}, 4'hf, 4'hf, 4'hf, 4'hf,
                1, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  {5'h00, CMD_NOP},    4'h0, 4'h0, 4'h0, 4'h0,
                1, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  {5'h15, CMD_SPARE6}, 4'hf, 4'hf, 4'hf, 4'hf,
                1, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  {5'h00, CMD_CREDIT}, 4'hf, 4'hf, 4'hf, 4'hf,
                1, 8'h00, 0, 4'h0);
        // free play: 100 credits, both lamps
        add_row(ACC_READ,  OFS_SYS,  8'h00, 4'hf, 4'hf, 4'hf, 4'hf, 1, 8'ha0, 1, LAMP_BOTH);
        // test switch masks the count; start 2 still goes through
        add_row(ACC_READ,  OFS_SYS,  8'h00, 4'h7, 4'h7, 4'hf, 4'hf, 1, TEST_READ, 1, LAMP_OFF);
        add_row(ACC_WRITE, OFS_SYS,  {5'h1f, CMD_SETUP},  4'hf, 4'hf, 4'hf, 4'hf,
                0, 8'h00, 0, 4'h0);
        // read inside the set-up while coinage A is still zero: credits go to 100
        add_row(ACC_READ,  OFS_SYS,  8'h00, 4'hf, 4'hf, 4'hf, 4'hf, 0, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  8'hf9, 4'hf, 4'hf, 4'hf, 4'hf, 0, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  8'h07, 4'hf, 4'hf, 4'hf, 4'hf, 0, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  8'h08, 4'hf, 4'hf, 4'hf, 4'hf, 0, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  8'hff, 4'hf, 4'hf, 4'hf, 4'hf, 0, 8'h00, 0, 4'h0);
        // coins while locked out
        add_row(ACC_READ,  OFS_SYS,  8'h00, 4'hf, 4'hc, 4'hf, 4'hf, 0, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  {5'h00, CMD_CREDIT}, 4'hf, 4'hf, 4'hf, 4'hf,
                0, 8'h00, 0, 4'h0);
        add_row(ACC_READ,  OFS_SYS,  8'h00, 4'h7, 4'hf, 4'hf, 4'hf, 0, 8'h00, 0, 4'h0);
        // both coins and service at once: credits pass the lockout value
        add_row(ACC_READ,  OFS_SYS,  8'h00, 4'hf, 4'h8, 4'hf, 4'hf, 0, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  {5'h0a, CMD_REMAP_ON}, 4'hf, 4'hf, 4'hf, 4'hf,
                0, 8'h00, 0, 4'h0);
        add_row(ACC_READ,  OFS_JOY1, 8'h00, 4'he, 4'hf, 4'h0, 4'hf, 0, 8'h00, 0, 4'h0);
        add_row(ACC_READ,  OFS_JOY2, 8'h00, 4'hc, 4'hf, 4'h0, 4'hf, 0, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  {5'h00, CMD_REMAP_OFF}, 4'hf, 4'hf, 4'hf, 4'hf,
                0, 8'h00, 0, 4'h0);
        add_row(ACC_READ,  OFS_JOY1, 8'h00, 4'hc, 4'hf, 4'h5, 4'ha, 0, 8'h00, 0, 4'h0);
        add_row(ACC_READ,  OFS_NONE, 8'h00, 4'h0, 4'h0, 4'h0, 4'h0, 0, 8'h00, 0, 4'h0);
        add_row(ACC_WRITE, OFS_SYS,  {5'h00, CMD_SWITCH}, 4'hf, 4'hf, 4'hf, 4'hf,
                0, 8'h00, 0, 4'h0);
    endfunction

    function automatic void build_random();
        int r;
        int n;
        while (accesses.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                push_access(random_write(8'($urandom)));
            end else if (r < 8) begin
                push_access(random_write({5'($urandom), CMD_SETUP}));
                if ($urandom_range(0, 2) == 0)
                    push_access(random_read(OFS_SYS));
                // now and then a cut-short set-up, so later writes land as coinage
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 4;
                repeat (n) push_access(random_write(8'($urandom)));
            end else if (r < 16) begin
                push_access(random_write({5'($urandom), CMD_CREDIT}));
            end else if (r < 18) begin
                push_access(random_write({5'($urandom), CMD_SWITCH}));
            end else if (r < 22) begin
                push_access(random_write({5'($urandom),
                                          ($urandom_range(0, 1) != 0) ? CMD_REMAP_ON
                                                                      : CMD_REMAP_OFF}));
            end else begin
                n = $urandom_range(0, 9);
                push_access(random_read((n < 6) ? OFS_SYS : (n < 8) ? OFS_JOY1 :
                                        (n < 9) ? OFS_JOY2 : OFS_NONE));
            end
        end
    endfunction

    function automatic int pick_gap(int k);
        int r;
        if (k >= CALM_LO && k < CALM_HI)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic string fmt_result(t_out_item r);
        return $sformatf("rd=%02h lkw=%0b lk=%0b pa=%0b pb=%0b o0w=%0b o0=%h",
                         r.read_data, r.lockout_written, r.coin_lockout, r.coin_a_pulse,
                         r.coin_b_pulse, r.out0_written, r.out0_value);
    endfunction

    // receiver: random stall stretches plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!pressure_done && n_results >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_left = PRESSURE_LEN - 1;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (n_results >= CALM_LO && n_results < CALM_HI) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = (($urandom_range(0, 9) == 0) ? $urandom_range(6, 30)
                                                      : $urandom_range(1, 3)) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result check, prediction on accepted accesses, watchdog
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                n_results <= n_results + 1;
                if (pending_results.size() == 0) begin
                    failures++;
                    if (failures <= SHOWN_ERRORS)
                        $display("unexpected result: %s", fmt_result(o_data));
                end else begin
                    want = pending_results.pop_front();
                    if (o_data !== want) begin
                        failures++;
                        if (failures <= SHOWN_ERRORS)
                            $display("mismatch on result %0d\n  got  %s\n  want %s",
                                     n_results, fmt_result(o_data), fmt_result(want));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                pred = predict_bus_result(i_data);
                if (accesses[acc_idx].typed)
                    pred = accesses[acc_idx].want;
                pending_results.push_back(pred);
                acc_idx++;
                if (pred.coin_lockout)
                    n_lockouts++;
                if (pred.coin_a_pulse || pred.coin_b_pulse)
                    n_coin_pulses++;
                if (pred.read_data == TEST_READ && i_data.cmd == ACC_READ)
                    n_test_reads++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("coin_credit_joystick_io_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        int gap;
        acc_idx       = 0;
        failures      = 0;
        idle_cycles   = 0;
        n_results     = 0;
        n_lockouts    = 0;
        n_coin_pulses = 0;
        n_test_reads  = 0;
        hold_left     = 0;
        stall_left    = 0;
        pressure_done = 1'b0;
        reset_predictor();
        build_directed();
        n_directed = accesses.size();
        build_random();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < accesses.size(); k++) begin
            gap = pick_gap(k);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data  <= accesses[k].acc;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d accesses (%0d directed), %0d results checked, %0d failures",
                 accesses.size(), n_directed, n_results, failures);
        $display("lockout reads %0d, coin counter pulses %0d, test switch reads %0d",
                 n_lockouts, n_coin_pulses, n_test_reads);
        if (failures == 0)
            $display("coin_credit_joystick_io_unit verification clean");
        else
            $display("coin_credit_joystick_io_unit verification failed");
        $finish;
    end

endmodule
